// ===== src/rbfc_pkg.sv =====
// Shared types, register codes and format helpers for the rectangle blit format converter.
package rbfc_pkg;

  localparam int OFFSET_W = 26;
  localparam int DIM_W    = 13;
  localparam int POS_W    = 12;
  localparam int FMT_W    = 3;
  localparam int IDX_W    = 4;

  localparam logic [IDX_W-1:0] REG_SRC_FORMAT  = 4'd0;
  localparam logic [IDX_W-1:0] REG_DST_FORMAT  = 4'd1;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH   = 4'd2;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT  = 4'd3;
  localparam logic [IDX_W-1:0] REG_DST_COL     = 4'd4;
  localparam logic [IDX_W-1:0] REG_DST_ROW     = 4'd5;
  localparam logic [IDX_W-1:0] REG_RECT_WIDTH  = 4'd6;
  localparam logic [IDX_W-1:0] REG_RECT_HEIGHT = 4'd7;
  localparam logic [IDX_W-1:0] REG_COUNT       = 4'd8;

  localparam logic [FMT_W-1:0] FMT_GRAY  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_GA    = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGB   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_RGBA  = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  // floor(n/3) == (n*683) >> 11 for every n below 2048.
  localparam logic [9:0] THIRD_MUL   = 10'd683;
  localparam int         THIRD_SHIFT = 11;

  typedef struct packed {
    logic [7:0] in_c0;
    logic [7:0] in_c1;
    logic [7:0] in_c2;
    logic [7:0] in_c3;
  } in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] dst_offset;
    logic [7:0]          out_c0;
    logic [7:0]          out_c1;
    logic [7:0]          out_c2;
    logic [7:0]          out_c3;
    logic [2:0]          byte_count;
    logic                last_pixel;
    logic                status;
  } out_t;

  typedef struct packed {
    logic [FMT_W-1:0] src_format;
    logic [FMT_W-1:0] dst_format;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
    logic [POS_W-1:0] dst_col;
    logic [POS_W-1:0] dst_row;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } cfg_t;

  // One classified pixel on its way from the front end to the converter.
  typedef struct packed {
    in_t                 pixel;
    logic [OFFSET_W-1:0] offset;
    logic                last;
    logic                ok;
  } item_t;

  function automatic logic [FMT_W-1:0] fmt_of(input logic [FMT_W-1:0] v);
    logic [FMT_W-1:0] f;
    if (v < FMT_GRAY) begin
      f = FMT_GRAY;
    end else if (v > FMT_RGBA) begin
      f = FMT_RGBA;
    end else begin
      f = v;
    end
    return f;
  endfunction

endpackage

// ===== src/rbfc_front.sv =====
// Front end: walks the rectangle, tracks the destination offset and classifies each pixel.
module rbfc_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  rbfc_pkg::cfg_t cfg,
  input  logic          restart,
  input  logic          accept,
  input  rbfc_pkg::in_t pixel,
  output rbfc_pkg::item_t item
);

  localparam int OW = rbfc_pkg::OFFSET_W;
  localparam int DW = rbfc_pkg::DIM_W;

  logic [DW-1:0] col_count, col_count_next;
  logic [DW-1:0] row_count, row_count_next;
  logic [OW-1:0] pixel_offset, pixel_offset_next;
  logic [OW-1:0] row_offset, row_offset_next;
  logic          need_start, need_start_next;

  logic [DW-1:0] walk_w, walk_h;
  logic [rbfc_pkg::FMT_W-1:0] df;
  logic [OW-1:0] start_offset, stride, cur_offset, cur_row;
  logic [OW-1:0] row_prod;
  logic          last, row_end, fits;
  logic [DW:0]   col_end, row_end_sum;

  function automatic logic [DW-1:0] walk_dim(input logic [DW-1:0] v);
    logic [DW-1:0] d;
    if (v == '0) begin
      d = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = DW'(MAX_DIM);
    end else begin
      d = v;
    end
    return d;
  endfunction

  always_comb begin
    walk_w = walk_dim(cfg.rect_width);
    walk_h = walk_dim(cfg.rect_height);
    df     = rbfc_pkg::fmt_of(cfg.dst_format);

    row_prod     = OW'(cfg.dst_row) * OW'(cfg.dst_width);
    start_offset = OW'((row_prod + OW'(cfg.dst_col)) * OW'(df));
    stride       = OW'(OW'(cfg.dst_width) * OW'(df));

    cur_offset = need_start ? start_offset : pixel_offset;
    cur_row    = need_start ? start_offset : row_offset;

    row_end = (col_count == walk_w - DW'(1));
    last    = row_end && (row_count == walk_h - DW'(1));

    col_end     = {1'b0, DW'(cfg.dst_col)} + {1'b0, cfg.rect_width};
    row_end_sum = {1'b0, DW'(cfg.dst_row)} + {1'b0, cfg.rect_height};
    fits = (cfg.rect_width != '0) && (cfg.rect_height != '0) &&
           (32'(cfg.dst_width) <= MAX_DIM) && (32'(cfg.dst_height) <= MAX_DIM) &&
           (col_end <= {1'b0, cfg.dst_width}) && (row_end_sum <= {1'b0, cfg.dst_height});

    item.pixel  = pixel;
    item.offset = cur_offset;
    item.last   = last;
    item.ok     = fits;
  end

  always_comb begin
    col_count_next    = col_count;
    row_count_next    = row_count;
    pixel_offset_next = pixel_offset;
    row_offset_next   = row_offset;
    need_start_next   = need_start;
    priority if (restart) begin
      col_count_next  = '0;
      row_count_next  = '0;
      need_start_next = 1'b1;
    end else if (accept) begin
      priority if (last) begin
        col_count_next  = '0;
        row_count_next  = '0;
        need_start_next = 1'b1;
      end else if (row_end) begin
        col_count_next    = '0;
        row_count_next    = row_count + DW'(1);
        row_offset_next   = cur_row + stride;
        pixel_offset_next = cur_row + stride;
        need_start_next   = 1'b0;
      end else begin
        col_count_next    = col_count + DW'(1);
        row_offset_next   = cur_row;
        pixel_offset_next = cur_offset + OW'(df);
        need_start_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      need_start <= 1'b1;
    end else begin
      col_count  <= col_count_next;
      row_count  <= row_count_next;
      need_start <= need_start_next;
    end
    pixel_offset <= pixel_offset_next;
    row_offset   <= row_offset_next;
  end

endmodule

// ===== src/rbfc_queue.sv =====
// Two-word queue between the front end and the converter.
module rbfc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  rbfc_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output rbfc_pkg::item_t rd_item,
  output logic [1:0]      count
);

  rbfc_pkg::item_t mem [2];
  logic            wr_ptr, rd_ptr;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ===== src/rbfc_back.sv =====
// Back end: converts the pixel format and holds the finished result word.
module rbfc_back (
  input  logic            clk,
  input  logic            rst,
  input  rbfc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  rbfc_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output rbfc_pkg::out_t  result
);

  logic                 res_valid;
  rbfc_pkg::out_t       res_next;
  logic [rbfc_pkg::FMT_W-1:0] sf, df;
  logic [7:0]           r, g, b, a, gray;
  logic [9:0]           sum;
  logic [19:0]          scaled;
  logic [7:0]           o0, o1, o2, o3;

  assign empty = !res_valid;
  assign q_pop = q_valid && (!res_valid || pop);

  always_comb begin
    sf     = rbfc_pkg::fmt_of(cfg.src_format);
    df     = rbfc_pkg::fmt_of(cfg.dst_format);
    sum    = 10'(q_item.pixel.in_c0) + 10'(q_item.pixel.in_c1) + 10'(q_item.pixel.in_c2);
    scaled = 20'(sum) * 20'(rbfc_pkg::THIRD_MUL);
    if (sf <= rbfc_pkg::FMT_GA) begin
      r    = q_item.pixel.in_c0;
      g    = q_item.pixel.in_c0;
      b    = q_item.pixel.in_c0;
      gray = q_item.pixel.in_c0;
      a    = (sf == rbfc_pkg::FMT_GA) ? q_item.pixel.in_c1 : rbfc_pkg::ALPHA_OPAQUE;
    end else begin
      r    = q_item.pixel.in_c0;
      g    = q_item.pixel.in_c1;
      b    = q_item.pixel.in_c2;
      gray = scaled[rbfc_pkg::THIRD_SHIFT +: 8];
      a    = (sf == rbfc_pkg::FMT_RGBA) ? q_item.pixel.in_c3 : rbfc_pkg::ALPHA_OPAQUE;
    end
    o0 = '0;
    o1 = '0;
    o2 = '0;
    o3 = '0;
    priority if (df == rbfc_pkg::FMT_GRAY) begin
      o0 = gray;
    end else if (df == rbfc_pkg::FMT_GA) begin
      o0 = gray;
      o1 = a;
    end else begin
      o0 = r;
      o1 = g;
      o2 = b;
      if (df == rbfc_pkg::FMT_RGBA) begin
        o3 = a;
      end
    end
    // A rectangle that misses the frame reports only its position marks.
    res_next.dst_offset = q_item.ok ? q_item.offset : '0;
    res_next.out_c0     = q_item.ok ? o0 : '0;
    res_next.out_c1     = q_item.ok ? o1 : '0;
    res_next.out_c2     = q_item.ok ? o2 : '0;
    res_next.out_c3     = q_item.ok ? o3 : '0;
    res_next.byte_count = q_item.ok ? df : '0;
    res_next.last_pixel = q_item.last;
    res_next.status     = !q_item.ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
    if (q_pop) begin
      result <= res_next;
    end
  end

endmodule

// ===== src/rect_blit_format_convert.sv =====
// Top level of the rectangle blit with pixel format conversion.
// Source pixels of one rectangle enter in raster order, one word per clock while full is
// low, and each yields one result word: its byte offset in the destination frame, the
// converted bytes and their count, a last-pixel mark and a fit status. The block sustains
// one pixel per clock while results are popped as they appear; that rate is set by the
// front end's running offset, which moves by the destination pixel size per column and by
// one precomputed row stride per row. A pixel that is taken is written into the two-word
// queue, and the converter then loads its result into the result register, which drives
// the output ports; full rises only when both the queue and the result register are
// occupied. Any write to a defined register restarts the walk at the rectangle's first
// pixel; write registers only while no pixel is in flight.
module rect_blit_format_convert #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  rbfc_pkg::in_t                  pixel,
  output logic                           empty,
  input  logic                           pop,
  output rbfc_pkg::out_t                 result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbfc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [rbfc_pkg::DIM_W-1:0]     cfg_data
);

  rbfc_pkg::cfg_t  cfg;
  rbfc_pkg::item_t front_item, q_item;
  logic            accept, restart, cfg_write, q_valid, q_pop;
  logic [1:0]      q_count;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write && (cfg_index < rbfc_pkg::REG_COUNT);
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_format  <= rbfc_pkg::FMT_RGBA;
      cfg.dst_format  <= rbfc_pkg::FMT_RGBA;
      cfg.dst_width   <= rbfc_pkg::DIM_W'(1);
      cfg.dst_height  <= rbfc_pkg::DIM_W'(1);
      cfg.dst_col     <= '0;
      cfg.dst_row     <= '0;
      cfg.rect_width  <= rbfc_pkg::DIM_W'(1);
      cfg.rect_height <= rbfc_pkg::DIM_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        rbfc_pkg::REG_SRC_FORMAT:  cfg.src_format  <= cfg_data[rbfc_pkg::FMT_W-1:0];
        rbfc_pkg::REG_DST_FORMAT:  cfg.dst_format  <= cfg_data[rbfc_pkg::FMT_W-1:0];
        rbfc_pkg::REG_DST_WIDTH:   cfg.dst_width   <= cfg_data;
        rbfc_pkg::REG_DST_HEIGHT:  cfg.dst_height  <= cfg_data;
        rbfc_pkg::REG_DST_COL:     cfg.dst_col     <= cfg_data[rbfc_pkg::POS_W-1:0];
        rbfc_pkg::REG_DST_ROW:     cfg.dst_row     <= cfg_data[rbfc_pkg::POS_W-1:0];
        rbfc_pkg::REG_RECT_WIDTH:  cfg.rect_width  <= cfg_data;
        rbfc_pkg::REG_RECT_HEIGHT: cfg.rect_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rbfc_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .accept  (accept),
    .pixel   (pixel),
    .item    (front_item)
  );

  rbfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_item  (front_item),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .count    (q_count)
  );

  rbfc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count != 2'd3)
    else $error("queue holds more than two words");

  a_error_word_clear: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status) |->
      (result.byte_count == 3'd0 && result.dst_offset == '0 && result.out_c0 == 8'd0))
    else $error("error word carries pixel data");

  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.status) |->
      (result.byte_count != 3'd0 && result.byte_count <= rbfc_pkg::FMT_RGBA))
    else $error("good word has a bad byte count");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (q_valid && empty) |=> !empty)
    else $error("waiting word not moved into an empty result register");

endmodule

// ===== tb/sv/rect_blit_format_convert_tb.sv =====
// Self-checking testbench for the rectangle blit with pixel format conversion.
`timescale 1ns / 1ps

module rect_blit_format_convert_tb;

  localparam int MAX_DIM       = 4096;
  localparam int RANDOM_PIXELS = 950;
  localparam int STALL_LIMIT   = 5000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  rbfc_pkg::in_t              pixel = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  rbfc_pkg::out_t             result;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [rbfc_pkg::IDX_W-1:0] cfg_index = '0;
  logic [rbfc_pkg::DIM_W-1:0] cfg_data = '0;

  bit steady = 1'b0;
  int pixels_sent = 0;
  int quiet = 0;

  rect_blit_format_convert #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Tracks the register file and the walk position, and holds the result words still owed.
  class blit_ledger;
    logic [rbfc_pkg::FMT_W-1:0] src_fmt;
    logic [rbfc_pkg::FMT_W-1:0] dst_fmt;
    int unsigned frame_w, frame_h, rect_col, rect_row, rect_w, rect_h;
    int unsigned col, row;
    rbfc_pkg::out_t owed_results[$];
    int unsigned errors, matched, last_marks, misfit_marks, writes;

    function new();
      src_fmt = rbfc_pkg::FMT_RGBA;
      dst_fmt = rbfc_pkg::FMT_RGBA;
      frame_w = 1;
      frame_h = 1;
      rect_col = 0;
      rect_row = 0;
      rect_w = 1;
      rect_h = 1;
      col = 0;
      row = 0;
    endfunction

    function int unsigned bpp(logic [rbfc_pkg::FMT_W-1:0] v);
      if (v < rbfc_pkg::FMT_GRAY) return rbfc_pkg::FMT_GRAY;
      if (v > rbfc_pkg::FMT_RGBA) return rbfc_pkg::FMT_RGBA;
      return v;
    endfunction

    function int unsigned span(int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function bit fits();
      return rect_w != 0 && rect_h != 0 && frame_w <= MAX_DIM && frame_h <= MAX_DIM &&
             rect_col + rect_w <= frame_w && rect_row + rect_h <= frame_h;
    endfunction

    function logic [rbfc_pkg::OFFSET_W-1:0] offset_of(int unsigned c, int unsigned r);
      longint unsigned y, x;
      y = longint'(rect_row) + r;
      x = longint'(rect_col) + c;
      return rbfc_pkg::OFFSET_W'((y * frame_w + x) * bpp(dst_fmt));
    endfunction

    function void write_reg(logic [rbfc_pkg::IDX_W-1:0] idx,
                            logic [rbfc_pkg::DIM_W-1:0] data);
      writes++;
      case (idx)
        rbfc_pkg::REG_SRC_FORMAT:  src_fmt = data[rbfc_pkg::FMT_W-1:0];
        rbfc_pkg::REG_DST_FORMAT:  dst_fmt = data[rbfc_pkg::FMT_W-1:0];
        rbfc_pkg::REG_DST_WIDTH:   frame_w = data;
        rbfc_pkg::REG_DST_HEIGHT:  frame_h = data;
        rbfc_pkg::REG_DST_COL:     rect_col = data[rbfc_pkg::POS_W-1:0];
        rbfc_pkg::REG_DST_ROW:     rect_row = data[rbfc_pkg::POS_W-1:0];
        rbfc_pkg::REG_RECT_WIDTH:  rect_w = data;
        rbfc_pkg::REG_RECT_HEIGHT: rect_h = data;
        default: return;
      endcase
      col = 0;
      row = 0;
    endfunction

    function void take_pixel(rbfc_pkg::in_t p);
      int unsigned sf, df, rw, rh, gray, alpha;
      logic [7:0] r, g, b;
      rbfc_pkg::out_t e;
      sf = bpp(src_fmt);
      df = bpp(dst_fmt);
      rw = span(rect_w);
      rh = span(rect_h);
      if (col >= rw || row >= rh) begin
        col = 0;
        row = 0;
      end
      e = '0;
      e.last_pixel = (col == rw - 1) && (row == rh - 1);
      if (sf <= rbfc_pkg::FMT_GA) begin
        r = p.in_c0;
        g = p.in_c0;
        b = p.in_c0;
        gray = p.in_c0;
        alpha = (sf == rbfc_pkg::FMT_GA) ? p.in_c1 : rbfc_pkg::ALPHA_OPAQUE;
      end else begin
        r = p.in_c0;
        g = p.in_c1;
        b = p.in_c2;
        gray = (int'(p.in_c0) + int'(p.in_c1) + int'(p.in_c2)) / 3;
        alpha = (sf == rbfc_pkg::FMT_RGBA) ? p.in_c3 : rbfc_pkg::ALPHA_OPAQUE;
      end
      if (fits()) begin
        e.dst_offset = offset_of(col, row);
        case (df)
          rbfc_pkg::FMT_GRAY: e.out_c0 = 8'(gray);
          rbfc_pkg::FMT_GA: begin
            e.out_c0 = 8'(gray);
            e.out_c1 = 8'(alpha);
          end
          default: begin
            e.out_c0 = r;
            e.out_c1 = g;
            e.out_c2 = b;
            if (df == rbfc_pkg::FMT_RGBA) e.out_c3 = 8'(alpha);
          end
        endcase
        e.byte_count = 3'(df);
      end else begin
        e.status = 1'b1;
      end
      owed_results.push_back(e);
      if (e.last_pixel) begin
        col = 0;
        row = 0;
      end else begin
        col++;
        if (col >= rw) begin
          col = 0;
          row++;
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(rbfc_pkg::out_t got);
      rbfc_pkg::out_t want;
      if (owed_results.size() == 0) begin
        $error("result word with no pixel outstanding: %p", got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("dst_offset", want.dst_offset, got.dst_offset);
      compare_field("out_c0", want.out_c0, got.out_c0);
      compare_field("out_c1", want.out_c1, got.out_c1);
      compare_field("out_c2", want.out_c2, got.out_c2);
      compare_field("out_c3", want.out_c3, got.out_c3);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("last_pixel", want.last_pixel, got.last_pixel);
      compare_field("status", want.status, got.status);
      matched++;
      if (want.last_pixel) last_marks++;
      if (want.status) misfit_marks++;
    endfunction
  endclass

  blit_ledger ledger = new();

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic rbfc_pkg::in_t rand_pixel();
    rbfc_pkg::in_t p;
    p.in_c0 = rand_byte();
    p.in_c1 = rand_byte();
    p.in_c2 = rand_byte();
    p.in_c3 = rand_byte();
    return p;
  endfunction

  function automatic rbfc_pkg::cfg_t make_setup(int sf, int df, int w, int h, int x, int y,
                                                int rw, int rh);
    rbfc_pkg::cfg_t c;
    c.src_format = rbfc_pkg::FMT_W'(sf);
    c.dst_format = rbfc_pkg::FMT_W'(df);
    c.dst_width = rbfc_pkg::DIM_W'(w);
    c.dst_height = rbfc_pkg::DIM_W'(h);
    c.dst_col = rbfc_pkg::POS_W'(x);
    c.dst_row = rbfc_pkg::POS_W'(y);
    c.rect_width = rbfc_pkg::DIM_W'(rw);
    c.rect_height = rbfc_pkg::DIM_W'(rh);
    return c;
  endfunction

  function automatic rbfc_pkg::cfg_t random_setup();
    int sf, df, w, h, rw, rh, x, y;
    sf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    df = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    case ($urandom_range(0, 9))
      0: begin
        // Small rectangle near the far corner of a large frame.
        w = $urandom_range(2048, MAX_DIM);
        h = $urandom_range(2048, MAX_DIM);
        rw = $urandom_range(1, 6);
        rh = $urandom_range(1, 4);
        x = w - rw - $urandom_range(0, 3);
        y = h - rh - $urandom_range(0, 3);
      end
      1: begin
        w = $urandom_range(100, MAX_DIM);
        h = $urandom_range(1, 8);
        rw = w;
        rh = $urandom_range(1, h);
        x = 0;
        y = h - rh;
      end
      2, 3: begin
        // Start from a tight fit and break exactly one rule.
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 40);
        rw = $urandom_range(1, w);
        rh = $urandom_range(1, h);
        x = w - rw;
        y = h - rh;
        case ($urandom_range(0, 6))
          0: x++;
          1: y++;
          2: rw = 0;
          3: rh = 0;
          4: rh = $urandom_range(MAX_DIM + 1, 8191);
          5: w = $urandom_range(MAX_DIM + 1, 8191);
          default: h = $urandom_range(MAX_DIM + 1, 8191);
        endcase
      end
      default: begin
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 40);
        rw = $urandom_range(1, (w < 6) ? w : 6);
        rh = $urandom_range(1, (h < 5) ? h : 5);
        x = $urandom_range(0, w - rw);
        y = $urandom_range(0, h - rh);
      end
    endcase
    return make_setup(sf, df, w, h, x, y, rw, rh);
  endfunction

  // Leaves cfg_valid high so that writes can go back to back; the caller lowers it.
  task automatic set_reg(logic [rbfc_pkg::IDX_W-1:0] idx, logic [rbfc_pkg::DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_reg(idx, data);
  endtask

  // Unused upper data bits carry noise, since the block keeps only the register's width.
  task automatic apply_setup(rbfc_pkg::cfg_t c);
    set_reg(rbfc_pkg::REG_SRC_FORMAT, {10'($urandom), c.src_format});
    set_reg(rbfc_pkg::REG_DST_FORMAT, {10'($urandom), c.dst_format});
    set_reg(rbfc_pkg::REG_DST_WIDTH, c.dst_width);
    set_reg(rbfc_pkg::REG_DST_HEIGHT, c.dst_height);
    set_reg(rbfc_pkg::REG_DST_COL, {1'($urandom), c.dst_col});
    set_reg(rbfc_pkg::REG_DST_ROW, {1'($urandom), c.dst_row});
    set_reg(rbfc_pkg::REG_RECT_WIDTH, c.rect_width);
    set_reg(rbfc_pkg::REG_RECT_HEIGHT, c.rect_height);
    cfg_valid <= 1'b0;
  endtask

  // A write past the last register must leave the walk where it is.
  task automatic stray_write();
    logic [rbfc_pkg::IDX_W-1:0] idx;
    idx = rbfc_pkg::REG_COUNT + rbfc_pkg::IDX_W'($urandom_range(0, 7));
    set_reg(idx, rbfc_pkg::DIM_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(rbfc_pkg::in_t p);
    push <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (full);
    ledger.take_pixel(p);
    pixels_sent++;
    if (!steady && $urandom_range(0, 99) < 10) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic stop_push();
    push <= 1'b0;
  endtask

  // Waits until every owed word has come back, then lets the pipeline settle.
  task automatic drain();
    while (ledger.owed_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(int count, bit hold_mid);
    for (int i = 0; i < count; i++) begin
      send_pixel(rand_pixel());
      if ((hold_mid && i == count / 2) || $urandom_range(0, 199) == 0) begin
        stop_push();
        do @(posedge clk); while (ledger.owed_results.size() != 0);
      end
    end
    stop_push();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) ledger.match_result(result);
      pop <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("rect_blit_format_convert verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    rbfc_pkg::in_t p;
    int k;
    int phase;
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one opaque white pixel into a one-pixel frame.
    p = '1;
    send_pixel(p);
    stop_push();
    drain();

    // Every pairing of source and destination format.
    apply_setup(make_setup(rbfc_pkg::FMT_GRAY, rbfc_pkg::FMT_GRAY, 16, 16, 2, 3, 4, 4));
    k = 0;
    for (int sf = rbfc_pkg::FMT_GRAY; sf <= rbfc_pkg::FMT_RGBA; sf++) begin
      for (int df = rbfc_pkg::FMT_GRAY; df <= rbfc_pkg::FMT_RGBA; df++) begin
        set_reg(rbfc_pkg::REG_SRC_FORMAT, rbfc_pkg::DIM_W'(sf));
        set_reg(rbfc_pkg::REG_DST_FORMAT, rbfc_pkg::DIM_W'(df));
        cfg_valid <= 1'b0;
        case (k % 4)
          0: p = '0;
          1: p = '1;
          2: begin
            p.in_c0 = 8'd1;
            p.in_c1 = 8'd1;
            p.in_c2 = 8'd0;
            p.in_c3 = 8'h80;
          end
          default: p = rand_pixel();
        endcase
        send_pixel(p);
        stop_push();
        drain();
        k++;
      end
    end

    // Exact fit, then the same rectangle one column too far right.
    apply_setup(make_setup(rbfc_pkg::FMT_RGB, rbfc_pkg::FMT_GA, 10, 6, 6, 3, 4, 3));
    send_pixel(rand_pixel());
    stop_push();
    drain();
    apply_setup(make_setup(rbfc_pkg::FMT_RGB, rbfc_pkg::FMT_GA, 10, 6, 7, 3, 4, 3));
    send_pixel(rand_pixel());
    stop_push();
    drain();

    // Largest frame with the rectangle in its last row.
    apply_setup(make_setup(rbfc_pkg::FMT_RGBA, rbfc_pkg::FMT_RGBA, MAX_DIM, MAX_DIM,
                           MAX_DIM - 2, MAX_DIM - 1, 2, 1));
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    stop_push();
    drain();

    // Format codes outside the defined range.
    apply_setup(make_setup(0, 7, 8, 8, 0, 0, 2, 2));
    send_pixel(rand_pixel());
    stop_push();
    drain();
    apply_setup(make_setup(7, 0, 8, 8, 0, 0, 2, 2));
    send_pixel(rand_pixel());
    stop_push();
    drain();

    // Frame wider than the block allows, then a rectangle of zero height.
    apply_setup(make_setup(rbfc_pkg::FMT_RGBA, rbfc_pkg::FMT_RGB, MAX_DIM + 1, 8, 0, 0, 2, 2));
    send_pixel(rand_pixel());
    stop_push();
    drain();
    apply_setup(make_setup(rbfc_pkg::FMT_RGB, rbfc_pkg::FMT_RGB, 8, 8, 0, 0, 3, 0));
    send_pixel(rand_pixel());
    stop_push();
    drain();

    // A write to an undefined index in the middle of a rectangle.
    apply_setup(make_setup(rbfc_pkg::FMT_GA, rbfc_pkg::FMT_RGBA, 8, 4, 5, 1, 3, 1));
    send_pixel(rand_pixel());
    stop_push();
    drain();
    stray_write();
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    stop_push();
    drain();

    target = pixels_sent + RANDOM_PIXELS;
    phase = 0;
    while (pixels_sent < target) begin
      if (phase > 0 && $urandom_range(0, 5) == 0) begin
        stray_write();
      end else begin
        apply_setup(random_setup());
      end
      steady <= (phase == 6);
      run_phase((phase == 6) ? 200 : $urandom_range(10, 60), phase == 2);
      drain();
      steady <= 1'b0;
      phase++;
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d pixels through %0d register writes in %0d random phases.",
             pixels_sent, ledger.writes, phase);
    $display("Checked %0d result words: %0d rectangle ends, %0d misfit pixels.",
             ledger.matched, ledger.last_marks, ledger.misfit_marks);
    if (ledger.errors == 0 && ledger.owed_results.size() == 0) begin
      $display("rect_blit_format_convert verification clean");
    end else begin
      $display("rect_blit_format_convert verification failed");
    end
    $finish;
  end

endmodule
